@@ hw/rtl/r2fft_pkg.sv @@
// Shared constants for the radix-2 FFT magnitude spectrum block.
package r2fft_pkg;

  // Point store word: one signed 32-bit real and imaginary part
  localparam int DATA_BITS = 32;
  localparam int ENTRY_BITS = 2 * DATA_BITS;

  // Result field widths
  localparam int MAG_BITS = 25;
  localparam int BIN_BITS = 9;

  // Square root unit: 64-bit radicand, 32-bit root
  localparam int SQ_BITS = 64;
  localparam int ROOT_BITS = 32;

  // Config register map (index = paddr[2])
  localparam int CFG_ADDR_BITS = 3;
  localparam logic REG_SIZE_LOG2 = 1'b0;
  localparam logic REG_INVERSE = 1'b1;
  localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

  // Input item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // pi in Q30, rounded
  localparam longint unsigned PI_Q30 = 64'd3373259426;

endpackage

@@ hw/rtl/r2fft_if.sv @@
// Item channels of the FFT block: command in, result out.
interface r2fft_cmd_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;
  logic [8:0]             bin_index;

  modport source (output valid, mode, sample, last, bin_index, input ready);
  modport sink (input valid, mode, sample, last, bin_index, output ready);
endinterface

interface r2fft_res_if;
  logic        valid;
  logic        ready;
  logic [24:0] magnitude;
  logic [24:0] peak;
  logic        overflow;

  modport source (output valid, magnitude, peak, overflow, input ready);
  modport sink (input valid, magnitude, peak, overflow, output ready);
endinterface

@@ hw/rtl/r2fft_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module r2fft_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [r2fft_pkg::SQ_BITS-1:0]   value,
  output logic                            done,
  output logic [r2fft_pkg::ROOT_BITS-1:0] root
);
  import r2fft_pkg::*;

  logic               busy;
  logic [SQ_BITS-1:0] rem;
  logic [SQ_BITS-1:0] res;
  logic [SQ_BITS-1:0] bitv;
  logic [SQ_BITS-1:0] trial;

  assign trial = res + bitv;
  assign root = res[ROOT_BITS-1:0];

  // one result bit per cycle; ends when the test bit shifts out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= value;
        res  <= '0;
        bitv <= {2'b01, {(SQ_BITS-2){1'b0}}};
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

endmodule

@@ hw/rtl/radix2_fft_magnitude_spectrum.sv @@
// Top level of the radix-2 FFT magnitude spectrum block.
// Mode 0 items load real samples into a point memory with one read and one
// write port, one item per cycle. The item marked last sets off the transform,
// and input stalls until it ends. The rest of the memory is zero padded. The
// points are then put in bit-reversed order. Next come (N/2)*log2(N) butterflies
// through one shared multiplier. Last, bins 0..N/2-1 are scanned for the peak
// (memory read, two squares, 32-step square root and its done cycle), and the
// ST_DONE state hands the result on. A mode 1 item with an in-range bin gets its
// magnitude the same way; an out-of-range bin gives zero, and in both cases the
// next item waits until the result is handed on. A result that the receiver
// has not taken holds the next result back, which stalls the input. After reset
// a clearing pass zeroes the point memory before the first item is taken.
module radix2_fft_magnitude_spectrum #(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [r2fft_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  r2fft_cmd_if.sink                         cmd,
  r2fft_res_if.source                       res
);
  import r2fft_pkg::*;

  localparam int A    = $clog2(MAX_POINTS);
  localparam int HALF = MAX_POINTS / 2;
  localparam int TWB  = TWIDDLE_BITS;
  localparam int F    = TWB - 1;
  localparam int PW   = DATA_BITS + TWB;
  localparam int AW   = PW + 1;
  localparam int TW   = DATA_BITS + 3;
  localparam int LGW  = $clog2(A + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_REV   = 3'd3;
  localparam logic [2:0] ST_BF    = 3'd4;
  localparam logic [2:0] ST_PEAK  = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic signed [AW-1:0] RNDC = AW'(longint'(1) << (F - 1));
  localparam logic signed [TW-1:0] S32MAX = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] S32MIN = TW'(-64'sd2147483648);

  // ---- twiddle table built at elaboration ----
  function automatic logic [127:0] taylor(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    longint          c;
    x2 = (x * x) >> 30;
    // sine series up to the ninth power
    s  = $signed(x);
    t  = ((x * x2) >> 30) / 64'd6;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + $signed(t);
    // cosine series up to the tenth power
    c  = longint'(1) << 30;
    t  = longint'(1) << 30;
    t  = ((t * x2) >> 30) / 64'd2;
    c  = c - $signed(t);
    t  = ((t * x2) >> 30) / 64'd12;
    c  = c + $signed(t);
    t  = ((t * x2) >> 30) / 64'd30;
    c  = c - $signed(t);
    t  = ((t * x2) >> 30) / 64'd56;
    c  = c + $signed(t);
    t  = ((t * x2) >> 30) / 64'd90;
    c  = c - $signed(t);
    return {c, s};
  endfunction

  function automatic logic [TWB-1:0] q30_to_tw(longint v);
    int              sh;
    longint          lim;
    longint          r;
    longint unsigned m;
    sh  = 30 - (TWB - 1);
    lim = (longint'(1) << (TWB - 1)) - 1;
    m   = (v < 0) ? -v : v;
    r   = $signed((m + (longint'(1) << (sh - 1))) >> sh);
    if (r > lim) r = lim;
    if (v < 0) r = -r;
    return r[TWB-1:0];
  endfunction

  function automatic logic [HALF*2*TWB-1:0] build_tw();
    logic [HALF*2*TWB-1:0] tab;
    longint unsigned       a;
    longint unsigned       b;
    longint unsigned       x;
    longint unsigned       quarter;
    longint unsigned       eighth;
    longint                c;
    longint                s;
    longint                tmp;
    logic [127:0]          cs;
    logic                  rot;
    tab     = '0;
    quarter = MAX_POINTS / 4;
    eighth  = MAX_POINTS / 8;
    for (int k = 0; k < HALF; k++) begin
      a   = k;
      rot = 1'b0;
      if (a >= quarter) begin
        a   = a - quarter;
        rot = 1'b1;
      end
      if (a > eighth) begin
        b  = quarter - a;
        x  = (b * 2 * PI_Q30 + MAX_POINTS / 2) / MAX_POINTS;
        cs = taylor(x);
        s  = cs[127:64];
        c  = cs[63:0];
      end else begin
        x  = (a * 2 * PI_Q30 + MAX_POINTS / 2) / MAX_POINTS;
        cs = taylor(x);
        c  = cs[127:64];
        s  = cs[63:0];
      end
      if (rot) begin
        tmp = c;
        c   = -s;
        s   = tmp;
      end
      tab[k*2*TWB +: 2*TWB] = {q30_to_tw(c), q30_to_tw(s)};
    end
    return tab;
  endfunction

  localparam logic [HALF*2*TWB-1:0] TW_TABLE = build_tw();

  function automatic logic [DATA_BITS-1:0] sat32(logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    r = v;
    if (v > S32MAX) r = S32MAX;
    else if (v < S32MIN) r = S32MIN;
    return r[DATA_BITS-1:0];
  endfunction

  // ---- registers ----
  logic [2:0]           state;
  logic [3:0]           ph;
  logic [2:0]           mph;
  logic [A:0]           cnt;
  logic [A:0]           zidx;
  logic [A:0]           ridx;
  logic [A-2:0]         k;
  logic [LGW-1:0]       st;
  logic [LGW-1:0]       lg_q;
  logic                 ovf_q;
  logic [3:0]           size_log2;
  logic                 inverse;
  logic [MAG_BITS-1:0]  peak_value;
  logic [MAG_BITS-1:0]  res_mag;
  logic                 res_ovf;
  logic                 out_valid;
  logic [MAG_BITS-1:0]  out_mag;
  logic [MAG_BITS-1:0]  out_peak;
  logic                 out_ovf;
  logic [A-1:0]         mag_addr;
  logic [ENTRY_BITS-1:0] swap_a;
  logic signed [DATA_BITS-1:0] xr, xi, ur, ui;
  logic signed [TWB-1:0] wr, wi;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_r, acc_i;
  logic signed [TW-1:0] tr, ti;
  logic [2*TWB-1:0]     tw_q;
  logic [DATA_BITS-1:0] ar, ai;
  logic [SQ_BITS-1:0]   mprod, msum;

  // point memory
  logic [ENTRY_BITS-1:0] mem [MAX_POINTS];
  logic [ENTRY_BITS-1:0] rdata;
  logic                  mem_we;
  logic [A-1:0]          mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [A-1:0]          mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // ---- config port ----
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_SIZE_LOG2: prdata = 32'(size_log2);
      REG_INVERSE:   prdata = 32'(inverse);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_LOG2_RESET;
      inverse   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SIZE_LOG2: size_log2 <= pwdata[3:0];
        REG_INVERSE:   inverse <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // ---- size decode ----
  logic [LGW-1:0] lg_cur;
  logic [A:0]     n_cur, n_q, nh_q;

  always_comb begin
    if (int'(size_log2) < 3) lg_cur = LGW'(3);
    else if (int'(size_log2) > A) lg_cur = LGW'(A);
    else lg_cur = LGW'(size_log2);
  end
  assign n_cur = (A+1)'(1) << lg_cur;
  assign n_q   = (A+1)'(1) << lg_q;
  assign nh_q  = n_q >> 1;

  // ---- address generation ----
  logic [A-1:0]   rev_full, rev_r;
  logic [A-1:0]   kk, bmask, bhalf, bi, bp, tw_full;
  logic [A-2:0]   tw_idx;
  logic [A-2:0]   k_last;
  logic           r_gt;

  always_comb begin
    for (int b = 0; b < A; b++) rev_full[b] = ridx[A-1-b];
  end
  assign rev_r   = rev_full >> (LGW'(A) - lg_q);
  assign r_gt    = rev_r > ridx[A-1:0];
  assign kk      = {1'b0, k};
  assign bhalf   = A'(1) << (st - LGW'(1));
  assign bmask   = bhalf - A'(1);
  assign bi      = ((kk & ~bmask) << 1) | (kk & bmask);
  assign bp      = bi | bhalf;
  assign tw_full = (kk & bmask) << (LGW'(A) - st);
  assign tw_idx  = tw_full[A-2:0];
  assign k_last  = (A-1)'(nh_q - (A+1)'(1));

  always_ff @(posedge clk) begin
    tw_q <= TW_TABLE[tw_idx*2*TWB +: 2*TWB];
  end

  // ---- butterfly datapath ----
  logic signed [DATA_BITS-1:0] mul_d;
  logic signed [TWB-1:0]       mul_w;
  logic signed [TW-1:0]        ur_x, ui_x;

  always_comb begin
    case (ph)
      4'd2:    begin mul_d = xr; mul_w = wr; end
      4'd3:    begin mul_d = xi; mul_w = wi; end
      4'd4:    begin mul_d = xi; mul_w = wr; end
      default: begin mul_d = xr; mul_w = wi; end
    endcase
  end
  assign ur_x = TW'(ur);
  assign ui_x = TW'(ui);

  always_ff @(posedge clk) begin
    prod <= mul_d * mul_w;
  end

  // ---- magnitude datapath ----
  logic [A-1:0]          mag_a;
  logic [DATA_BITS-1:0]  mop;
  logic                  sq_start;
  logic                  sq_done;
  logic [ROOT_BITS-1:0]  sq_root;
  logic [MAG_BITS-1:0]   mag_val;
  logic signed [DATA_BITS-1:0] rd_re, rd_im;

  assign mag_a    = (state == ST_PEAK) ? kk : mag_addr;
  assign mop      = (mph == 3'd2) ? ar : ai;
  assign sq_start = ((state == ST_PEAK) || (state == ST_READ)) && (mph == 3'd4);
  assign mag_val  = (sq_root[ROOT_BITS-1:MAG_BITS+1] != '0) ? '1 : sq_root[MAG_BITS:1];
  assign rd_re    = rdata[ENTRY_BITS-1:DATA_BITS];
  assign rd_im    = rdata[DATA_BITS-1:0];

  always_ff @(posedge clk) begin
    mprod <= mop * mop;
  end

  r2fft_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (msum + mprod),
    .done  (sq_done),
    .root  (sq_root)
  );

  // ---- input decode ----
  logic       in_acc;
  logic [A:0] cnt_inc;

  assign cmd.ready = (state == ST_IDLE);
  assign in_acc    = cmd.valid && cmd.ready;
  assign cnt_inc   = (cnt <= (A+1)'(MAX_POINTS)) ? cnt + (A+1)'(1) : cnt;

  // ---- memory port control ----
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      ST_CLEAR, ST_ZERO: begin
        mem_we    = (zidx != (A+1)'(MAX_POINTS));
        mem_waddr = zidx[A-1:0];
      end
      ST_IDLE: begin
        mem_we    = in_acc && (cmd.mode == MODE_LOAD) && (cnt < n_cur);
        mem_waddr = cnt[A-1:0];
        mem_wdata = {DATA_BITS'($signed(cmd.sample[SAMPLE_BITS-1:0])), {DATA_BITS{1'b0}}};
      end
      ST_REV: begin
        mem_raddr = (ph == 4'd0) ? ridx[A-1:0] : rev_r;
        if (ph == 4'd2) begin
          mem_we    = 1'b1;
          mem_waddr = ridx[A-1:0];
          mem_wdata = rdata;
        end else if (ph == 4'd3) begin
          mem_we    = 1'b1;
          mem_waddr = rev_r;
          mem_wdata = swap_a;
        end
      end
      ST_BF: begin
        mem_raddr = (ph == 4'd0) ? bp : bi;
        if (ph == 4'd8) begin
          mem_we    = 1'b1;
          mem_waddr = bi;
          mem_wdata = {sat32(ur_x + tr), sat32(ui_x + ti)};
        end else if (ph == 4'd9) begin
          mem_we    = 1'b1;
          mem_waddr = bp;
          mem_wdata = {sat32(ur_x - tr), sat32(ui_x - ti)};
        end
      end
      ST_PEAK, ST_READ: mem_raddr = mag_a;
      default: ;
    endcase
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      zidx       <= '0;
      ph         <= '0;
      mph        <= '0;
      cnt        <= '0;
      peak_value <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && res.ready && (state != ST_DONE)) out_valid <= 1'b0;

      case (state)
        // reset clearing pass over the whole point memory
        ST_CLEAR: begin
          if (zidx == (A+1)'(MAX_POINTS)) state <= ST_IDLE;
          else zidx <= zidx + (A+1)'(1);
        end

        ST_IDLE: begin
          if (in_acc) begin
            if (cmd.mode == MODE_LOAD) begin
              if (cmd.last) begin
                ovf_q <= cnt_inc > n_cur;
                lg_q  <= lg_cur;
                zidx  <= (cnt_inc > n_cur) ? n_cur : cnt_inc;
                cnt   <= '0;
                state <= ST_ZERO;
              end else begin
                cnt <= cnt_inc;
              end
            end else begin
              res_ovf <= 1'b0;
              // during a load, entries past the loaded samples read as zero
              if ((32'(cmd.bin_index) < 32'(n_cur >> 1)) &&
                  ((cnt == '0) || (32'(cmd.bin_index) < 32'(cnt)))) begin
                mag_addr <= A'(cmd.bin_index);
                mph      <= '0;
                state    <= ST_READ;
              end else begin
                res_mag <= '0;
                state   <= ST_DONE;
              end
            end
          end
        end

        // zero padding past the loaded samples
        ST_ZERO: begin
          if (zidx == (A+1)'(MAX_POINTS)) begin
            ridx  <= '0;
            ph    <= '0;
            state <= ST_REV;
          end else begin
            zidx <= zidx + (A+1)'(1);
          end
        end

        // bit-reversed reorder, swapping each pair once
        ST_REV: begin
          if (ph == 4'd0 && !r_gt) begin
            if (ridx == n_q - (A+1)'(1)) begin
              st    <= LGW'(1);
              k     <= '0;
              state <= ST_BF;
            end else begin
              ridx <= ridx + (A+1)'(1);
            end
          end else if (ph == 4'd3) begin
            ph <= '0;
            if (ridx == n_q - (A+1)'(1)) begin
              st    <= LGW'(1);
              k     <= '0;
              state <= ST_BF;
            end else begin
              ridx <= ridx + (A+1)'(1);
            end
          end else begin
            if (ph == 4'd1) swap_a <= rdata;
            ph <= ph + 4'd1;
          end
        end

        // one butterfly: read, four products, round, write back
        ST_BF: begin
          if (ph != 4'd9) ph <= ph + 4'd1;
          case (ph)
            4'd1: begin
              xr <= rd_re;
              xi <= rd_im;
              wr <= tw_q[2*TWB-1:TWB];
              wi <= inverse ? -$signed(tw_q[TWB-1:0]) : $signed(tw_q[TWB-1:0]);
            end
            4'd2: begin
              ur <= rd_re;
              ui <= rd_im;
            end
            4'd3: acc_r <= AW'(prod);
            4'd4: acc_r <= acc_r - AW'(prod);
            4'd5: acc_i <= AW'(prod);
            4'd6: acc_i <= acc_i + AW'(prod);
            4'd7: begin
              tr <= TW'((acc_r + RNDC) >>> F);
              ti <= TW'((acc_i + RNDC) >>> F);
            end
            4'd9: begin
              ph <= '0;
              if (k == k_last) begin
                k <= '0;
                if (st == lg_q) begin
                  peak_value <= '0;
                  mph        <= '0;
                  state      <= ST_PEAK;
                end else begin
                  st <= st + LGW'(1);
                end
              end else begin
                k <= k + (A-1)'(1);
              end
            end
            default: ;
          endcase
        end

        // magnitude of one bin, for the peak scan or a read item
        ST_PEAK, ST_READ: begin
          case (mph)
            3'd1: begin
              ar  <= rd_re[DATA_BITS-1] ? DATA_BITS'(-rd_re) : DATA_BITS'(rd_re);
              ai  <= rd_im[DATA_BITS-1] ? DATA_BITS'(-rd_im) : DATA_BITS'(rd_im);
              mph <= mph + 3'd1;
            end
            3'd3: begin
              msum <= mprod;
              mph  <= mph + 3'd1;
            end
            3'd5: begin
              if (sq_done) begin
                mph <= '0;
                if (state == ST_READ) begin
                  res_mag <= mag_val;
                  state   <= ST_DONE;
                end else begin
                  if (mag_val > peak_value) peak_value <= mag_val;
                  if (k == k_last) begin
                    res_mag <= '0;
                    res_ovf <= ovf_q;
                    state   <= ST_DONE;
                  end else begin
                    k <= k + (A-1)'(1);
                  end
                end
              end
            end
            default: mph <= mph + 3'd1;
          endcase
        end

        // hand the result to the output register
        ST_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_mag   <= res_mag;
            out_peak  <= peak_value;
            out_ovf   <= res_ovf;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid     = out_valid;
  assign res.magnitude = out_mag;
  assign res.peak      = out_peak;
  assign res.overflow  = out_ovf;

endmodule

@@ tb/radix2_fft_magnitude_spectrum_tb.sv @@
// Self-checking testbench for the radix-2 FFT magnitude spectrum block.
module radix2_fft_magnitude_spectrum_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import r2fft_pkg::*;

  localparam int NPTS = 1024;
  localparam int TW_F = 15;
  localparam int IDLE_GAP = 200;
  localparam int HOLD_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint unsigned MAG_SAT = (64'd1 << 25) - 1;

  typedef struct packed {
    logic [24:0] magnitude;
    logic [24:0] peak;
    logic        overflow;
  } spec_res_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  r2fft_cmd_if #(.SAMPLE_BITS(16)) cmd_ch ();
  r2fft_res_if res_ch ();

  radix2_fft_magnitude_spectrum u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd_ch), .res(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Spectrum model state
  longint pt_re [NPTS];
  longint pt_im [NPTS];
  longint tw_cos [NPTS/2];
  longint tw_sin [NPTS/2];
  int unsigned samples_loaded;
  longint unsigned peak_mag;
  logic [3:0] size_cfg;
  logic inv_cfg;

  spec_res_t spectrum_q[$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  longint cycles = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int rx_phase_left = 0;
  bit rx_calm = 1'b1;

  // Series cos/sin in Q30 for 0 <= x <= pi/4
  function automatic void cos_sin_q30(input longint unsigned x, output longint cq,
                                      output longint sq);
    longint unsigned x2, t, dv;
    longint s, c;
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    c = longint'(64'd1 << 30);
    for (int n = 1; n <= 4; n++) begin
      dv = longint'((2 * n) * (2 * n + 1));
      t = ((t * x2) >> 30) / dv;
      s = (n % 2) ? s - longint'(t) : s + longint'(t);
    end
    t = 64'd1 << 30;
    for (int n = 1; n <= 5; n++) begin
      dv = longint'((2 * n - 1) * (2 * n));
      t = ((t * x2) >> 30) / dv;
      c = (n % 2) ? c - longint'(t) : c + longint'(t);
    end
    cq = c;
    sq = s;
  endfunction

  function automatic longint q30_to_q15(input longint v);
    longint unsigned m;
    longint r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = longint'((m + (64'd1 << 14)) >> 15);
    if (r > 32767) r = 32767;
    return (v < 0) ? -r : r;
  endfunction

  function automatic void build_twiddles();
    longint unsigned a, b, x;
    longint c, s, tmp;
    bit rot;
    for (int k = 0; k < NPTS / 2; k++) begin
      a = k;
      rot = 1'b0;
      if (a >= NPTS / 4) begin
        a -= NPTS / 4;
        rot = 1'b1;
      end
      if (a > NPTS / 8) begin
        b = NPTS / 4 - a;
        x = (b * 2 * PI_Q30 + NPTS / 2) / NPTS;
        cos_sin_q30(x, s, c);
      end else begin
        x = (a * 2 * PI_Q30 + NPTS / 2) / NPTS;
        cos_sin_q30(x, c, s);
      end
      if (rot) begin
        tmp = c;
        c = -s;
        s = tmp;
      end
      tw_cos[k] = q30_to_q15(c);
      tw_sin[k] = q30_to_q15(s);
    end
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int unsigned active_log2();
    if (size_cfg < 3) return 3;
    if (size_cfg > 10) return 10;
    return size_cfg;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned half_magnitude(input int b);
    longint unsigned ar, ai, m;
    ar = (pt_re[b] < 0) ? longint'(-pt_re[b]) : longint'(pt_re[b]);
    ai = (pt_im[b] < 0) ? longint'(-pt_im[b]) : longint'(pt_im[b]);
    m = int_sqrt(ar * ar + ai * ai) >> 1;
    return (m > MAG_SAT) ? MAG_SAT : m;
  endfunction

  // In-place decimation-in-time transform with rounded Q15 twiddles
  function automatic void run_fft(input int unsigned lg);
    int unsigned n, r, t, half, stride, p;
    longint tmp, wr, wi, xr, xi, tr, ti, ur, ui;
    n = 1 << lg;
    for (int unsigned i = 0; i < n; i++) begin
      r = 0;
      t = i;
      for (int unsigned b = 0; b < lg; b++) begin
        r = (r << 1) | (t & 1);
        t >>= 1;
      end
      if (r > i) begin
        tmp = pt_re[i]; pt_re[i] = pt_re[r]; pt_re[r] = tmp;
        tmp = pt_im[i]; pt_im[i] = pt_im[r]; pt_im[r] = tmp;
      end
    end
    for (int unsigned len = 2; len <= n; len <<= 1) begin
      half = len / 2;
      stride = NPTS / len;
      for (int unsigned j = 0; j < half; j++) begin
        wr = tw_cos[j * stride];
        wi = inv_cfg ? -tw_sin[j * stride] : tw_sin[j * stride];
        for (int unsigned i = j; i < n; i += len) begin
          p = i + half;
          xr = pt_re[p];
          xi = pt_im[p];
          tr = (wr * xr - wi * xi + (64'sd1 << (TW_F - 1))) >>> TW_F;
          ti = (wr * xi + wi * xr + (64'sd1 << (TW_F - 1))) >>> TW_F;
          ur = pt_re[i];
          ui = pt_im[i];
          pt_re[p] = clip32(ur - tr);
          pt_im[p] = clip32(ui - ti);
          pt_re[i] = clip32(ur + tr);
          pt_im[i] = clip32(ui + ti);
        end
      end
    end
  endfunction

  // Expected result of one accepted item, if it causes one
  function automatic void predict_spectrum(input logic m, input logic [15:0] s,
                                           input logic l, input logic [8:0] b);
    int unsigned lg, n;
    longint unsigned mag;
    spec_res_t r;
    lg = active_log2();
    n = 1 << lg;
    if (m == MODE_READ) begin
      r.magnitude = (b < n / 2) ? 25'(half_magnitude(b)) : '0;
      r.peak = 25'(peak_mag);
      r.overflow = 1'b0;
      spectrum_q.push_back(r);
      return;
    end
    if (samples_loaded == 0) begin
      foreach (pt_re[i]) begin
        pt_re[i] = 0;
        pt_im[i] = 0;
      end
    end
    if (samples_loaded < n) pt_re[samples_loaded] = longint'($signed(s));
    if (samples_loaded < NPTS + 1) samples_loaded++;
    if (!l) return;
    r.overflow = (samples_loaded > n);
    run_fft(lg);
    peak_mag = 0;
    for (int k = 0; k < n / 2; k++) begin
      mag = half_magnitude(k);
      if (mag > peak_mag) peak_mag = mag;
    end
    samples_loaded = 0;
    r.magnitude = '0;
    r.peak = 25'(peak_mag);
    spectrum_q.push_back(r);
  endfunction

  // Result checker and receiver stall pattern
  always @(posedge clk) begin
    spec_res_t want;
    cycles <= cycles + 1;
    if (res_ch.valid && res_ch.ready) begin
      if (spectrum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: mag %0d peak %0d ovf %0d",
                                       res_ch.magnitude, res_ch.peak, res_ch.overflow);
      end else begin
        want = spectrum_q.pop_front();
        if (res_ch.magnitude !== want.magnitude || res_ch.peak !== want.peak ||
            res_ch.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mag %0d peak %0d ovf %0d, got mag %0d peak %0d ovf %0d",
                     want.magnitude, want.peak, want.overflow,
                     res_ch.magnitude, res_ch.peak, res_ch.overflow);
        end
      end
    end
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= rx_calm ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
    if (rx_phase_left == 0) begin
      rx_calm <= ~rx_calm;
      rx_phase_left <= $urandom_range(20, 200);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("radix2_fft_magnitude_spectrum test failed");
      $finish;
    end
  end

  task automatic cmd_idle();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Bursty sender pacing after each accepted item
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic send_item(input logic m, input logic [15:0] s, input logic l,
                           input logic [8:0] b);
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.sample <= s;
    cmd_ch.last <= l;
    cmd_ch.bin_index <= b;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_spectrum(m, s, l, b);
    items_sent++;
    pace_sender();
  endtask

  task automatic read_bin(input int b);
    send_item(MODE_READ, 16'($urandom), 1'b0, 9'(b));
  endtask

  task automatic wait_drained();
    cmd_idle();
    while (spectrum_q.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_SIZE_LOG2) size_cfg = v[3:0];
    else inv_cfg = v[0];
  endtask

  task automatic set_config(input logic [3:0] lg, input logic inv);
    wait_drained();
    write_reg(REG_SIZE_LOG2, {28'd0, lg});
    write_reg(REG_INVERSE, {31'd0, inv});
  endtask

  task automatic load_frame(input int count, input bit extremes);
    logic [15:0] s;
    for (int i = 0; i < count; i++) begin
      s = 16'($urandom);
      if (extremes) begin
        case ($urandom_range(0, 3))
          0: s = 16'h7fff;
          1: s = 16'h8000;
          default: ;
        endcase
      end
      send_item(MODE_LOAD, s, i == count - 1, 9'($urandom));
    end
  endtask

  // Reads right after reset see a zero store
  task automatic test_read_before_transform();
    read_bin(0);
    read_bin(3);
    read_bin(511);
  endtask

  // Small frame with extreme samples, all bins plus out-of-range bins
  task automatic test_extreme_frame();
    logic [15:0] vals [8] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
                              16'hffff, 16'h7fff, 16'h8000, 16'h5555};
    set_config(4'd3, 1'b0);
    foreach (vals[i]) send_item(MODE_LOAD, vals[i], i == 7, 9'h1ff);
    for (int b = 0; b < 5; b++) read_bin(b);
    read_bin(511);
  endtask

  // One sample only: rest is zero padded
  task automatic test_zero_padding();
    send_item(MODE_LOAD, 16'h8000, 1'b1, 9'd0);
    read_bin(2);
  endtask

  // More samples than the size sets overflow
  task automatic test_overflow();
    load_frame(11, 1'b0);
    read_bin(1);
  endtask

  task automatic test_inverse();
    set_config(4'd4, 1'b1);
    load_frame(16, 1'b1);
    read_bin(5);
  endtask

  // Sizes outside the range clamp to 3 and 10
  task automatic test_size_clamp();
    set_config(4'd0, 1'b0);
    load_frame(5, 1'b0);
    read_bin(3);
    read_bin(4);
    set_config(4'd15, 1'b1);
    load_frame(4, 1'b1);
    read_bin(511);
    read_bin(1);
  endtask

  // Random frames over several settings, with some broken sequences
  task automatic test_random_frames(input int target);
    int unsigned n;
    int cnt;
    while (items_sent < target) begin
      set_config(($urandom_range(0, 9) == 0) ? 4'($urandom_range(7, 8))
                                               : 4'($urandom_range(3, 6)),
                 $urandom_range(0, 1));
      n = 1 << active_log2();
      repeat ($urandom_range(1, 3)) begin
        cnt = ($urandom_range(0, 9) == 0) ? n + $urandom_range(1, 3)
                                          : $urandom_range(1, n);
        // occasionally read in the middle of a load
        if ($urandom_range(0, 7) == 0) begin
          load_frame(0, 1'b0);
          send_item(MODE_LOAD, 16'($urandom), 1'b0, 9'($urandom));
          read_bin($urandom_range(0, n / 2 - 1));
          cnt = (cnt > 1) ? cnt - 1 : 1;
        end
        load_frame(cnt, $urandom_range(0, 3) == 0);
        repeat ($urandom_range(2, 10)) begin
          if ($urandom_range(0, 4) == 0) read_bin($urandom_range(0, 511));
          else read_bin($urandom_range(0, n / 2 - 1));
        end
      end
    end
  endtask

  // Long receiver hold-off while reads keep coming
  task automatic test_backpressure();
    set_config(4'd3, 1'b0);
    load_frame(8, 1'b0);
    hold_req <= 1'b1;
    repeat (60) read_bin($urandom_range(0, 511));
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= MODE_LOAD;
    cmd_ch.sample <= '0;
    cmd_ch.last <= 1'b0;
    cmd_ch.bin_index <= '0;
    foreach (pt_re[i]) begin
      pt_re[i] = 0;
      pt_im[i] = 0;
    end
    samples_loaded = 0;
    peak_mag = 0;
    size_cfg = SIZE_LOG2_RESET;
    inv_cfg = 1'b0;
    build_twiddles();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_read_before_transform();
    test_extreme_frame();
    test_zero_padding();
    test_overflow();
    test_inverse();
    test_size_clamp();
    test_random_frames(1600);
    test_backpressure();

    wait_drained();
    if (mismatches == 0) begin
      $display("radix2_fft_magnitude_spectrum test passed");
    end else begin
      $display("radix2_fft_magnitude_spectrum test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_if.sv
hw/rtl/r2fft_isqrt.sv
hw/rtl/radix2_fft_magnitude_spectrum.sv
tb/radix2_fft_magnitude_spectrum_tb.sv
